>>> rtl/cpe_pkg.sv
// Shared types, codes and AES helper functions for the crypto PE datapath.
`default_nettype none
package cpe_pkg;

    typedef logic [3:0][31:0] word4_t;

    // stage-one op codes
    localparam logic [2:0] OP_PASS = 3'd0;
    localparam logic [2:0] OP_ADD2 = 3'd1;
    localparam logic [2:0] OP_ADD3 = 3'd2;
    localparam logic [2:0] OP_SUB2 = 3'd3;
    localparam logic [2:0] OP_SUB3 = 3'd4;
    localparam logic [2:0] OP_SUBB = 3'd5;
    localparam logic [2:0] OP_MIXC = 3'd6;

    // logic unit codes
    localparam logic [2:0] LU_A       = 3'd0;
    localparam logic [2:0] LU_XOR     = 3'd1;
    localparam logic [2:0] LU_OR      = 3'd2;
    localparam logic [2:0] LU_AND     = 3'd3;
    localparam logic [2:0] LU_NOT     = 3'd4;
    localparam logic [2:0] LU_NOT_XOR = 3'd5;
    localparam logic [2:0] LU_NOT_OR  = 3'd6;
    localparam logic [2:0] LU_NOT_AND = 3'd7;

    // shifter codes
    localparam logic [1:0] SH_SLL = 2'd0;
    localparam logic [1:0] SH_SRL = 2'd1;
    localparam logic [1:0] SH_ROL = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    localparam logic [31:0] SR_CODE_RESET = 32'hFFFF_FFFF;
    localparam logic [7:0]  AES_POLY      = 8'h1b;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? AES_POLY : 8'h00);
    endfunction

    // one AES column, MSB byte is row 0
    function automatic logic [31:0] mix_word(input logic [31:0] w);
        logic [7:0] b0, b1, b2, b3, o0, o1, o2, o3;
        b0 = w[31:24];
        b1 = w[23:16];
        b2 = w[15:8];
        b3 = w[7:0];
        o0 = xtime(b0) ^ xtime(b1) ^ b1 ^ b2 ^ b3;
        o1 = b0 ^ xtime(b1) ^ xtime(b2) ^ b2 ^ b3;
        o2 = b0 ^ b1 ^ xtime(b2) ^ xtime(b3) ^ b3;
        o3 = xtime(b0) ^ b0 ^ b1 ^ b2 ^ xtime(b3);
        return {o0, o1, o2, o3};
    endfunction

    function automatic logic [31:0] logic_unit(input logic [2:0] code,
                                               input logic [31:0] a,
                                               input logic [31:0] b);
        logic [31:0] r;
        case (code)
            LU_A:       r = a;
            LU_XOR:     r = a ^ b;
            LU_OR:      r = a | b;
            LU_AND:     r = a & b;
            LU_NOT:     r = ~a;
            LU_NOT_XOR: r = ~a ^ b;
            LU_NOT_OR:  r = ~a | b;
            default:    r = ~a & b;
        endcase
        return r;
    endfunction

    // amt[5] set means 32 or more: shifts give zero, rotates ignore it
    function automatic logic [31:0] shifter(input logic [1:0] code,
                                            input logic [31:0] x,
                                            input logic [5:0] amt);
        logic [63:0] dbl;
        logic [31:0] r;
        dbl = {x, x};
        case (code)
            SH_SLL:  r = amt[5] ? 32'd0 : (x << amt[4:0]);
            SH_SRL:  r = amt[5] ? 32'd0 : (x >> amt[4:0]);
            SH_ROL:  r = dbl[63 - amt[4:0] -: 32];
            default: r = dbl[31 + amt[4:0] -: 32];
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/cpe_stage1.sv
// Stage-one unit: add/sub on word0, SubBytes or MixColumns on all words.
`default_nettype none
module cpe_stage1 (
    input  wire logic [2:0]      op1,
    input  wire cpe_pkg::word4_t raw,
    output cpe_pkg::word4_t      w
);
    import cpe_pkg::*;

    always_comb
    begin
        w = raw;
        case (op1)
            OP_PASS: ;
            OP_ADD2: w[0] = raw[0] + raw[1];
            OP_ADD3: w[0] = raw[0] + raw[1] + raw[2];
            OP_SUB2: w[0] = raw[0] - raw[1];
            OP_SUB3: w[0] = raw[0] - raw[1] - raw[2];
            OP_SUBB:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    w[i] = sub_word(raw[i]);
                end
            end
            OP_MIXC:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    w[i] = mix_word(raw[i]);
                end
            end
            default: w = '0;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/crypto_pe_alu_datapath_top.sv
// Top level of the crypto PE datapath: input register, compute, result register.
//
// Usage:
//   Command channel: drive op1, control_word and in_word0..3 with start high.
//   busy is always low, so a word is taken at every edge where start is high,
//   one word per cycle sustained.
//   Result channel: done is high for one cycle per result, with out_word0..3.
//   A taken word passes the input register, then the result register, and
//   shows its result with done. Results come out in order.
//   The receiver cannot stall; it must take each result in its done cycle.
//   Config: cfg_we/cfg_wdata write the shift-rows code; write it only while
//   no command is in flight.
//   Reset: rst_n low clears the pipeline valid flags (no spurious done) and
//   sets the shift-rows code to all ones.
//   Throughput is set by the single compute stage between the two registers:
//   stage-one unit, then logic units and shifters, no iteration.
`default_nettype none
module crypto_pe_alu_datapath_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  op1,
    input  wire logic [31:0] control_word,
    input  wire logic [31:0] in_word0,
    input  wire logic [31:0] in_word1,
    input  wire logic [31:0] in_word2,
    input  wire logic [31:0] in_word3,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    output logic             done,
    output logic [31:0]      out_word0,
    output logic [31:0]      out_word1,
    output logic [31:0]      out_word2,
    output logic [31:0]      out_word3
);
    import cpe_pkg::*;

    logic        in_vld_reg;
    logic        done_reg;
    logic [31:0] sr_code_reg;
    logic [2:0]  op1_reg;
    logic [31:0] cw_reg;
    word4_t      raw_reg;
    word4_t      res_reg;
    word4_t      res_next;
    word4_t      w1;
    word4_t      wk;
    logic        accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
            sr_code_reg <= SR_CODE_RESET;
        end
        else
        begin
            in_vld_reg <= accept;
            done_reg   <= in_vld_reg;
            if (cfg_we)
            begin
                sr_code_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op1_reg <= op1;
            cw_reg  <= control_word;
            raw_reg <= {in_word3, in_word2, in_word1, in_word0};
        end
        if (in_vld_reg)
        begin
            res_reg <= res_next;
        end
    end

    cpe_stage1 u_stage1 (
        .op1 (op1_reg),
        .raw (raw_reg),
        .w   (w1)
    );

    always_comb
    begin
        logic [31:0] lu1, lu2, s1, s2, s3, lu3;
        logic [5:0]  amt3;
        wk = w1;
        if (cw_reg != 32'd0)
        begin
            wk[1] = raw_reg[1];
            wk[2] = raw_reg[2];
            wk[3] = raw_reg[3];
        end
        // zero control word forces a shift by 32 on sru3
        amt3 = (cw_reg == 32'd0) ? 6'd32 : cw_reg[8:3];
        lu1  = logic_unit(cw_reg[30:28], wk[0], wk[3]);
        lu2  = logic_unit(cw_reg[27:25], wk[1], wk[2]);
        s1   = shifter(cw_reg[24:23], lu1, {1'b0, cw_reg[22:18]});
        s2   = shifter(cw_reg[17:16], lu2, {1'b0, cw_reg[15:11]});
        s3   = shifter(cw_reg[10:9], wk[3], amt3);
        lu3  = (cw_reg[2:0] == LU_A) ? s2 : logic_unit(cw_reg[2:0], s1, s2);
        if (cw_reg == sr_code_reg)
        begin
            // ShiftRows over the stage-one columns
            for (int i = 0; i < 4; i++)
            begin
                res_next[i] = {w1[i][31:24], w1[(i + 1) % 4][23:16],
                               w1[(i + 2) % 4][15:8], w1[(i + 3) % 4][7:0]};
            end
        end
        else
        begin
            res_next[0] = s1;
            res_next[1] = lu3 ^ s3;
            res_next[2] = cw_reg[31] ? wk[0] : wk[2];
            res_next[3] = wk[3];
        end
    end

    assign done      = done_reg;
    assign out_word0 = res_reg[0];
    assign out_word1 = res_reg[1];
    assign out_word2 = res_reg[2];
    assign out_word3 = res_reg[3];

`ifndef SYNTHESIS
    a_accept_to_valid: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_vld_reg)
        else $error("accepted word did not enter the compute stage");
    a_valid_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg |=> done)
        else $error("compute stage word produced no done strobe");
    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !in_vld_reg |=> !done)
        else $error("done without a word in the compute stage");
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> sr_code_reg == $past(cfg_wdata))
        else $error("shift-rows code not updated by write");
`endif

endmodule
`default_nettype wire
